@@ rtl/dafp_pkg.sv @@
// Shared types and constants for the DNS A-record frame parser.
`timescale 1ns / 1ps

package dafp_pkg;

    localparam int MAX_FRAME_DEFAULT = 2048;

    localparam logic [7:0] IPV4_VER_IHL = 8'h45;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PTR_MIN      = 8'hC0;

    localparam int OFS_VER_IHL  = 14;
    localparam int OFS_PROTO    = 23;
    localparam int DNS_BASE     = 14 + 20 + 8;
    localparam int DNS_HDR_END  = 14 + 20 + 8 + 12;
    localparam int OFS_ID_HI    = DNS_BASE;
    localparam int OFS_ID_LO    = DNS_BASE + 1;
    localparam int OFS_AN_HI    = DNS_BASE + 6;
    localparam int OFS_AN_LO    = DNS_BASE + 7;
    localparam int QTAIL_LEN    = 4;

    localparam logic [15:0] RR_TYPE_A   = 16'd1;
    localparam logic [15:0] RR_RDLEN_A  = 16'd4;

    // Parse phases, one-hot
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_QNAME   = 7'b0000010,
        PH_ZSKIP   = 7'b0000100,
        PH_ANAME   = 7'b0001000,
        PH_ALABELS = 7'b0010000,
        PH_RR      = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
    } verdict_t;

endpackage

@@ rtl/dafp_in_reg.sv @@
// Input register for frame bytes.
`timescale 1ns / 1ps

module dafp_in_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    output logic                 frame_stall,
    input  dafp_pkg::frame_item_t item_in,
    input  logic                 result_ready,
    output logic                 advance,
    output dafp_pkg::frame_item_t item_out
);

    logic                  valid_reg;
    logic                  valid_next;
    dafp_pkg::frame_item_t item_reg;
    logic                  load;

    // A last byte moves on only when the result register can take its verdict
    assign advance     = valid_reg && (!item_reg.last || result_ready);
    assign frame_stall = valid_reg && !advance;
    assign load        = frame_valid && !frame_stall;
    assign item_out    = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

endmodule

@@ rtl/dafp_parser.sv @@
// Per-byte frame parse state and verdict logic.
`timescale 1ns / 1ps

module dafp_parser
#(
    parameter int MAX_FRAME = dafp_pkg::MAX_FRAME_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  dafp_pkg::frame_item_t item,
    input  logic [15:0]           expected_id,
    output logic                  verdict_valid,
    output dafp_pkg::verdict_t    verdict
);

    // Marks reach at most MAX_FRAME - 1 + 255 + 1
    localparam int CW = $clog2(MAX_FRAME + 256);

    logic [CW-1:0]     byte_count_reg, byte_count_next;
    logic [CW-1:0]     next_mark_reg, next_mark_next;
    dafp_pkg::phase_t  phase_reg, phase_next;
    logic              failed_reg, failed_next;
    logic [7:0]        held_reg, held_next;
    logic              type_ok_reg, type_ok_next;
    logic [31:0]       addr_reg, addr_next;

    logic [CW-1:0]     idx;
    logic [7:0]        b;
    logic [15:0]       word;
    logic              over;
    logic              at_mark;
    logic              past_mark;
    logic [CW-1:0]     off;
    logic [CW-1:0]     mark_step;
    logic              is_ptr;
    logic              is_zero;
    logic              ok;

    assign idx       = byte_count_reg;
    assign b         = item.data;
    assign word      = {held_reg, b};
    assign over      = idx >= CW'(MAX_FRAME);
    assign at_mark   = idx == next_mark_reg;
    assign past_mark = idx >= next_mark_reg;
    assign off       = idx - next_mark_reg;
    assign mark_step = CW'(idx + CW'(b) + CW'(1));
    assign is_ptr    = b >= dafp_pkg::PTR_MIN;
    assign is_zero   = b == 8'd0;

    always_comb
    begin
        byte_count_next = over ? idx : CW'(idx + CW'(1));
        next_mark_next  = next_mark_reg;
        phase_next      = phase_reg;
        failed_next     = failed_reg || over;
        held_next       = held_reg;
        type_ok_next    = type_ok_reg;
        addr_next       = addr_reg;

        if (!failed_next)
        begin
            unique case (phase_reg)
                dafp_pkg::PH_HEADER:
                begin
                    if (idx == CW'(dafp_pkg::OFS_VER_IHL) && b != dafp_pkg::IPV4_VER_IHL)
                    begin
                        failed_next = 1'b1;
                    end
                    if (idx == CW'(dafp_pkg::OFS_PROTO) && b != dafp_pkg::PROTO_UDP)
                    begin
                        failed_next = 1'b1;
                    end
                    if (idx == CW'(dafp_pkg::OFS_ID_HI) || idx == CW'(dafp_pkg::OFS_AN_HI))
                    begin
                        held_next = b;
                    end
                    if (idx == CW'(dafp_pkg::OFS_ID_LO) && word != expected_id)
                    begin
                        failed_next = 1'b1;
                    end
                    if (idx == CW'(dafp_pkg::OFS_AN_LO) && word == 16'd0)
                    begin
                        failed_next = 1'b1;
                    end
                    if (idx == CW'(dafp_pkg::DNS_HDR_END - 1))
                    begin
                        phase_next     = dafp_pkg::PH_QNAME;
                        next_mark_next = CW'(idx + CW'(1));
                    end
                end
                dafp_pkg::PH_QNAME:
                begin
                    if (at_mark)
                    begin
                        if (is_zero)
                        begin
                            next_mark_next = CW'(idx + CW'(1 + dafp_pkg::QTAIL_LEN));
                            phase_next     = dafp_pkg::PH_ANAME;
                        end
                        else if (is_ptr)
                        begin
                            next_mark_next = CW'(idx + CW'(2));
                            phase_next     = dafp_pkg::PH_ZSKIP;
                        end
                        else
                        begin
                            next_mark_next = mark_step;
                        end
                    end
                end
                dafp_pkg::PH_ZSKIP:
                begin
                    // Skip one stray zero byte after a compression pointer
                    if (at_mark)
                    begin
                        next_mark_next = is_zero ? CW'(idx + CW'(1 + dafp_pkg::QTAIL_LEN))
                                                 : CW'(idx + CW'(dafp_pkg::QTAIL_LEN));
                        phase_next     = dafp_pkg::PH_ANAME;
                    end
                end
                dafp_pkg::PH_ANAME:
                begin
                    if (at_mark)
                    begin
                        if (is_ptr)
                        begin
                            next_mark_next = CW'(idx + CW'(2));
                            phase_next     = dafp_pkg::PH_RR;
                        end
                        else if (is_zero)
                        begin
                            next_mark_next = CW'(idx + CW'(1));
                            phase_next     = dafp_pkg::PH_RR;
                        end
                        else
                        begin
                            next_mark_next = mark_step;
                            phase_next     = dafp_pkg::PH_ALABELS;
                        end
                    end
                end
                dafp_pkg::PH_ALABELS:
                begin
                    if (at_mark)
                    begin
                        if (is_zero)
                        begin
                            next_mark_next = CW'(idx + CW'(1));
                            phase_next     = dafp_pkg::PH_RR;
                        end
                        else
                        begin
                            next_mark_next = mark_step;
                        end
                    end
                end
                dafp_pkg::PH_RR:
                begin
                    if (past_mark)
                    begin
                        if (off == CW'(0) || off == CW'(8))
                        begin
                            held_next = b;
                        end
                        else if (off == CW'(1))
                        begin
                            type_ok_next = word == dafp_pkg::RR_TYPE_A;
                        end
                        else if (off == CW'(9))
                        begin
                            type_ok_next = type_ok_reg && (word == dafp_pkg::RR_RDLEN_A);
                            failed_next  = !type_ok_next;
                        end
                        else if (off >= CW'(10) && off <= CW'(13))
                        begin
                            addr_next = {addr_reg[23:0], b};
                            if (off == CW'(13))
                            begin
                                phase_next = dafp_pkg::PH_DONE;
                            end
                        end
                    end
                end
                dafp_pkg::PH_DONE:
                begin
                    // Ignore trailing bytes
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign ok              = (phase_next == dafp_pkg::PH_DONE) && !failed_next;
    assign verdict_valid   = take && item.last;
    assign verdict.found   = ok;
    assign verdict.address = ok ? addr_next : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            next_mark_reg  <= '0;
            phase_reg      <= dafp_pkg::PH_HEADER;
            failed_reg     <= 1'b0;
            held_reg       <= '0;
            type_ok_reg    <= 1'b0;
            addr_reg       <= '0;
        end
        else if (take)
        begin
            if (item.last)
            begin
                // Drop all per-frame state after the verdict
                byte_count_reg <= '0;
                next_mark_reg  <= '0;
                phase_reg      <= dafp_pkg::PH_HEADER;
                failed_reg     <= 1'b0;
                held_reg       <= '0;
                type_ok_reg    <= 1'b0;
                addr_reg       <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                next_mark_reg  <= next_mark_next;
                phase_reg      <= phase_next;
                failed_reg     <= failed_next;
                held_reg       <= held_next;
                type_ok_reg    <= type_ok_next;
                addr_reg       <= addr_next;
            end
        end
    end

endmodule

@@ rtl/dafp_out_reg.sv @@
// Result register holding one verdict.
`timescale 1ns / 1ps

module dafp_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  dafp_pkg::verdict_t verdict_in,
    output logic               ready,
    output logic               result_valid,
    input  logic               result_stall,
    output dafp_pkg::verdict_t verdict_out
);

    logic               valid_reg;
    logic               valid_next;
    dafp_pkg::verdict_t verdict_reg;

    assign ready        = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign verdict_out  = verdict_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict_in;
        end
    end

endmodule

@@ rtl/dns_a_record_frame_parser.sv @@
// Top level of the DNS A-record frame parser.
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Transaction
// -------   ---------  -----------------------------------  -------------------------------
// frame     in         frame_valid, frame_stall,            one Ethernet frame byte
//                      frame_byte, frame_end
// result    out        result_valid, result_stall,          one verdict per frame, sent
//                      found, ipv4_address                  after the frame_end byte
// config    in         cfg_we, cfg_wdata                    expected DNS transaction id
//
// Each byte lands in the input register, the parser updates its frame state from it as
// the byte advances, and the last byte's verdict goes to the result register.
// A new byte is accepted every cycle unless frame_stall is high; frame_stall rises only
// while a last byte waits on a result register that is still full and stalled. Reset
// clears the counters, the parse phase, both valid flags and expected_id; expected_id
// is sampled as the DNS id bytes pass the parser.

module dns_a_record_frame_parser
#(
    parameter int MAX_FRAME = dafp_pkg::MAX_FRAME_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [31:0] ipv4_address,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]           expected_id_reg;
    dafp_pkg::frame_item_t item_in;
    dafp_pkg::frame_item_t item_q;
    logic                  advance;
    logic                  result_ready;
    logic                  verdict_valid;
    dafp_pkg::verdict_t    verdict;
    dafp_pkg::verdict_t    verdict_q;

    // Hold the id register across frames; only the config port and reset update it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            expected_id_reg <= cfg_wdata;
        end
    end

    assign item_in.data = frame_byte;
    assign item_in.last = frame_end;

    // Input register: accept a byte while it is empty or the parser stage can advance
    dafp_in_reg u_in_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .item_in      (item_in),
        .result_ready (result_ready),
        .advance      (advance),
        .item_out     (item_q)
    );

    // Parser: one byte per advance, verdict on the last byte
    dafp_parser
    #(
        .MAX_FRAME (MAX_FRAME)
    )
    u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (advance),
        .item          (item_q),
        .expected_id   (expected_id_reg),
        .verdict_valid (verdict_valid),
        .verdict       (verdict)
    );

    // Result register: hold the verdict until the consumer takes it
    dafp_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (verdict_valid),
        .verdict_in   (verdict),
        .ready        (result_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict_out  (verdict_q)
    );

    assign found        = verdict_q.found;
    assign ipv4_address = verdict_q.address;

endmodule
